/* rtl/mkds_pkg.sv */
`default_nettype none

package mkds_pkg;

    localparam int ROWS = 4;
    localparam int COLS = 4;

    // the input carries a fixed 16-bit snapshot; keys past it cannot be seen
    localparam int INPUT_BITS = 16;
    localparam int KEY_COUNT  = (ROWS * COLS < INPUT_BITS) ? ROWS * COLS : INPUT_BITS;
    localparam int KEY_W      = 4;

    localparam int LIMIT_W   = 16;
    localparam int STEP_W    = 10;
    localparam int ELAPSED_W = 17;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd40;
    localparam logic [STEP_W-1:0]  STEP_RESET  = 10'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_STEP      = 2'd1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic             found;
        logic [KEY_W-1:0] key;
    } scan_t;

    // first pressed key in row-major order
    function automatic scan_t find_key(input logic [INPUT_BITS-1:0] matrix);
        scan_t res;
        res.found = 1'b0;
        res.key   = '0;
        for (int i = KEY_COUNT - 1; i >= 0; i--)
        begin
            if (matrix[i])
            begin
                res.found = 1'b1;
                res.key   = KEY_W'(i);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/matrix_keypad_debounced_scanner.sv */
// An accepted scan beat waits in the queue; its mode update and result beat are registered.
// Throughput: one scan beat per cycle while result_ready stays high; the encoder is
// combinational, and a two-entry queue plus the output register absorb stalls downstream.
// Reset (rst_n, async, active low): mode scanning, latched key and timer zero,
// debounce_limit 40, tick_step 10, queue and output register empty.
`default_nettype none

module matrix_keypad_debounced_scanner
    import mkds_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    input  wire logic                  scan_valid,
    output logic                       scan_ready,
    input  wire logic [INPUT_BITS-1:0] key_matrix,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output logic                       release_valid,
    output logic [KEY_W-1:0]           released_key
);

    logic              q_full;
    logic              q_push;
    logic              q_pop;
    logic              q_not_empty;
    scan_t             q_entry;
    scan_t             q_head;
    logic [QCNT_W-1:0] q_level;

    mkds_front u_front (
        .scan_valid (scan_valid),
        .scan_ready (scan_ready),
        .key_matrix (key_matrix),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_entry    (q_entry)
    );

    mkds_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head),
        .level      (q_level)
    );

    mkds_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_not_empty   (q_not_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .release_valid (release_valid),
        .released_key  (released_key)
    );

    // a non-release beat always carries key zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !release_valid) |-> (released_key == '0))
        else $error("released_key nonzero without release");

    // a fresh result beat must come from a queued scan
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(q_level != '0))
        else $error("result beat with no queued scan");

    // queue never overruns or underruns
    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full) && !(q_pop && !q_not_empty))
        else $error("queue overrun or underrun");

    // queue level rises by one on a push without a pop
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && !q_pop) |=> (q_level == $past(q_level) + 1'b1))
        else $error("queue level did not advance on push");

endmodule

`default_nettype wire

/* rtl/mkds_front.sv */
`default_nettype none

module mkds_front
    import mkds_pkg::*;
(
    input  wire logic                  scan_valid,
    output logic                       scan_ready,
    input  wire logic [INPUT_BITS-1:0] key_matrix,
    input  wire logic                  q_full,
    output logic                       q_push,
    output scan_t                      q_entry
);

    assign scan_ready = !q_full;
    assign q_push     = scan_valid && !q_full;
    assign q_entry    = find_key(key_matrix);

endmodule

`default_nettype wire

/* rtl/mkds_queue.sv */
`default_nettype none

module mkds_queue
    import mkds_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire scan_t             push_entry,
    output logic                   full,
    input  wire logic              pop,
    output logic                   not_empty,
    output scan_t                  head,
    output logic [QCNT_W-1:0]      level
);

    scan_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];
    assign level     = count_reg;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/mkds_back.sv */
`default_nettype none

module mkds_back
    import mkds_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 q_not_empty,
    input  wire scan_t                q_head,
    output logic                      q_pop,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output logic                      release_valid,
    output logic [KEY_W-1:0]          released_key
);

    typedef enum logic [1:0] {
        MODE_SCANNING = 2'd0,
        MODE_DEBOUNCE = 2'd1,
        MODE_HELD     = 2'd2
    } mode_t;

    mode_t                  mode_reg, mode_next;
    logic [KEY_W-1:0]       latched_reg, latched_next;
    logic [ELAPSED_W-1:0]   elapsed_reg, elapsed_next;
    logic [LIMIT_W-1:0]     limit_reg, limit_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic                   res_valid_reg, res_valid_next;
    logic                   rel_valid_reg, rel_valid_next;
    logic [KEY_W-1:0]       rel_key_reg, rel_key_next;
    logic [ELAPSED_W:0]     elapsed_sum;

    assign q_pop         = q_not_empty && (!res_valid_reg || result_ready);
    assign result_valid  = res_valid_reg;
    assign release_valid = rel_valid_reg;
    assign released_key  = rel_key_reg;

    assign elapsed_sum = {1'b0, elapsed_reg} + (ELAPSED_W + 1)'(step_reg);

    always_comb
    begin
        mode_next      = mode_reg;
        latched_next   = latched_reg;
        elapsed_next   = elapsed_reg;
        limit_next     = limit_reg;
        step_next      = step_reg;
        rel_valid_next = rel_valid_reg;
        rel_key_next   = rel_key_reg;
        res_valid_next = res_valid_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEBOUNCE_LIMIT: limit_next = cfg_data[LIMIT_W-1:0];
                CFG_TICK_STEP:      step_next  = cfg_data[STEP_W-1:0];
                default:            ;
            endcase
        end

        if (result_ready)
        begin
            res_valid_next = 1'b0;
        end

        if (q_pop)
        begin
            res_valid_next = 1'b1;
            rel_valid_next = 1'b0;
            rel_key_next   = '0;
            case (mode_reg)
                MODE_DEBOUNCE:
                begin
                    if (elapsed_reg >= ELAPSED_W'(limit_reg))
                    begin
                        if (q_head.found && q_head.key == latched_reg)
                        begin
                            mode_next = MODE_HELD;
                        end
                        else
                        begin
                            mode_next = MODE_SCANNING;
                        end
                    end
                    // saturate at the 17-bit ceiling
                    elapsed_next = elapsed_sum[ELAPSED_W] ? '1 : elapsed_sum[ELAPSED_W-1:0];
                end
                MODE_HELD:
                begin
                    if (!q_head.found || q_head.key != latched_reg)
                    begin
                        mode_next = MODE_SCANNING;
                        if (!q_head.found)
                        begin
                            rel_valid_next = 1'b1;
                            rel_key_next   = latched_reg;
                        end
                    end
                end
                default:
                begin
                    if (q_head.found)
                    begin
                        latched_next = q_head.key;
                        elapsed_next = '0;
                        mode_next    = MODE_DEBOUNCE;
                    end
                    else
                    begin
                        mode_next = MODE_SCANNING;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_SCANNING;
            latched_reg   <= '0;
            elapsed_reg   <= '0;
            limit_reg     <= LIMIT_RESET;
            step_reg      <= STEP_RESET;
            res_valid_reg <= 1'b0;
            rel_valid_reg <= 1'b0;
            rel_key_reg   <= '0;
        end
        else
        begin
            mode_reg      <= mode_next;
            latched_reg   <= latched_next;
            elapsed_reg   <= elapsed_next;
            limit_reg     <= limit_next;
            step_reg      <= step_next;
            res_valid_reg <= res_valid_next;
            rel_valid_reg <= rel_valid_next;
            rel_key_reg   <= rel_key_next;
        end
    end

endmodule

`default_nettype wire

/* tb/sv/tb_matrix_keypad_debounced_scanner.sv */
`default_nettype none

module tb_matrix_keypad_debounced_scanner;
    import mkds_pkg::*;

    typedef enum logic [1:0] {
        SCANNING = 2'd0,
        DEBOUNCE = 2'd1,
        HELD     = 2'd2
    } keypad_mode_t;

    // indexes with no register behind them; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam logic [ELAPSED_W-1:0] ELAPSED_CAP = '1;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
    } release_t;

    class release_tracker;
        keypad_mode_t           mode;
        logic [KEY_W-1:0]       held_key;
        logic [ELAPSED_W-1:0]   elapsed;
        logic [LIMIT_W-1:0]     limit;
        logic [STEP_W-1:0]      step;
        release_t               expected_q[$];
        int unsigned            mismatches;
        int unsigned            checked;
        int unsigned            releases;

        function new();
            mode       = SCANNING;
            held_key   = '0;
            elapsed    = '0;
            limit      = LIMIT_RESET;
            step       = STEP_RESET;
            mismatches = 0;
            checked    = 0;
            releases   = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_DEBOUNCE_LIMIT: limit = data[LIMIT_W-1:0];
                CFG_TICK_STEP:      step  = data[STEP_W-1:0];
                default: ;
            endcase
        endfunction

        function bit lowest_pressed(logic [INPUT_BITS-1:0] matrix, output logic [KEY_W-1:0] k);
            k = '0;
            for (int b = 0; b < ROWS * COLS; b++)
            begin
                if (b < INPUT_BITS && matrix[b])
                begin
                    k = KEY_W'(b);
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void scan_accepted(logic [INPUT_BITS-1:0] matrix);
            release_t           r;
            logic [KEY_W-1:0]   k;
            bit                 hit;
            logic [ELAPSED_W:0] sum;
            r = '0;
            case (mode)
                DEBOUNCE:
                begin
                    if (elapsed >= ELAPSED_W'(limit))
                    begin
                        hit  = lowest_pressed(matrix, k);
                        mode = (hit && k == held_key) ? HELD : SCANNING;
                    end
                    sum     = {1'b0, elapsed} + (ELAPSED_W + 1)'(step);
                    elapsed = (sum > {1'b0, ELAPSED_CAP}) ? ELAPSED_CAP : sum[ELAPSED_W-1:0];
                end
                HELD:
                begin
                    hit = lowest_pressed(matrix, k);
                    if (!hit || k != held_key)
                    begin
                        if (!hit)
                        begin
                            r.valid = 1'b1;
                            r.key   = held_key;
                        end
                        mode = SCANNING;
                    end
                end
                default:
                begin
                    hit = lowest_pressed(matrix, k);
                    if (hit)
                    begin
                        held_key = k;
                        elapsed  = '0;
                        mode     = DEBOUNCE;
                    end
                    else
                    begin
                        mode = SCANNING;
                    end
                end
            endcase
            expected_q.push_back(r);
        endfunction

        function void result_seen(logic v, logic [KEY_W-1:0] k);
            release_t want;
            checked++;
            if (v)
                releases++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: release_valid=%0b released_key=%0d", v, k);
                return;
            end
            want = expected_q.pop_front();
            if (want.valid !== v || want.key !== k)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: expected release_valid=%0b released_key=%0d, got %0b/%0d",
                             checked, want.valid, want.key, v, k);
            end
        endfunction
    endclass

    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index    = '0;
    logic [CFG_W-1:0]        cfg_data     = '0;
    logic                    scan_valid   = 1'b0;
    logic [INPUT_BITS-1:0]   key_matrix   = '0;
    logic                    result_ready = 1'b0;
    wire logic               scan_ready;
    wire logic               result_valid;
    wire logic               release_valid;
    wire logic [KEY_W-1:0]   released_key;

    release_tracker tracker = new();
    int unsigned    scans_sent   = 0;
    int unsigned    burst_left   = 0;
    int unsigned    settings_run = 1;

    matrix_keypad_debounced_scanner u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .scan_valid    (scan_valid),
        .scan_ready    (scan_ready),
        .key_matrix    (key_matrix),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .release_valid (release_valid),
        .released_key  (released_key)
    );

    always #5 clk = ~clk;

    // receiver: rotating stall pattern, rerolled whenever pattern_age wraps; some windows never stall
    logic [15:0] stall_pattern = 16'hFFFF;
    int unsigned pattern_age   = 0;

    always @(posedge clk)
    begin
        if (pattern_age == 63)
        begin
            pattern_age   <= 0;
            stall_pattern <= ($urandom_range(3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        end
        else
        begin
            pattern_age   <= pattern_age + 1;
            stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
        end
        result_ready <= stall_pattern[15];
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            tracker.result_seen(release_valid, released_key);
    end

    task automatic send_scan(logic [INPUT_BITS-1:0] matrix);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
            if (gap > 0)
            begin
                scan_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        scan_valid <= 1'b1;
        key_matrix <= matrix;
        do
            @(posedge clk);
        while (!scan_ready);
        tracker.scan_accepted(matrix);
        scans_sent++;
        burst_left--;
    endtask

    task automatic drain();
        scan_valid <= 1'b0;
        burst_left = 0;
        while (tracker.expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        tracker.set_register(idx, data);
    endtask

    task automatic reconfigure(logic [CFG_W-1:0] limit_data, logic [CFG_W-1:0] step_data);
        drain();
        write_reg(CFG_DEBOUNCE_LIMIT, limit_data);
        write_reg(CFG_TICK_STEP, step_data);
        write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, CFG_W'($urandom));
        cfg_we <= 1'b0;
        settings_run++;
    endtask

    // ticks from first press until the key is confirmed held; large when it never confirms
    function automatic int unsigned confirm_ticks();
        int unsigned lim;
        int unsigned stp;
        lim = tracker.limit;
        stp = tracker.step;
        if (stp == 0)
            return (lim == 0) ? 2 : 32'hFFFF_FFFF;
        return 2 + (lim + stp - 1) / stp;
    endfunction

    task automatic play_keystroke();
        logic [KEY_W-1:0]      k;
        logic [INPUT_BITS-1:0] above;
        logic [INPUT_BITS-1:0] press;
        int unsigned           need;
        int unsigned           hold;
        k     = KEY_W'($urandom_range(15));
        above = ~((INPUT_BITS'(2) << k) - 1'b1);
        need  = confirm_ticks();
        hold  = need + $urandom_range(0, 4);
        // let go before the debounce check
        if ($urandom_range(4) == 0)
            hold = $urandom_range(1, need - 1);
        for (int unsigned i = 0; i < hold; i++)
        begin
            press = (INPUT_BITS'(1) << k) |
                    (($urandom_range(1) == 1) ? (INPUT_BITS'($urandom) & above) : '0);
            if ($urandom_range(19) == 0)
                press = INPUT_BITS'($urandom);  // contact bounce
            send_scan(press);
        end
        if ($urandom_range(4) == 0)
            send_scan(INPUT_BITS'(1) << $urandom_range(15));  // roll over to another key
        else
            repeat ($urandom_range(1, 2)) send_scan('0);
    endtask

    task automatic random_phase(int unsigned count);
        int unsigned           start;
        logic [INPUT_BITS-1:0] noise;
        start = scans_sent;
        while (scans_sent - start < count)
        begin
            if (confirm_ticks() <= 100 && $urandom_range(9) < 8)
            begin
                play_keystroke();
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    case ($urandom_range(3))
                        0:       noise = '0;
                        1:       noise = INPUT_BITS'(1) << $urandom_range(15);
                        default: noise = INPUT_BITS'($urandom);
                    endcase
                    send_scan(noise);
                end
            end
        end
    endtask

    localparam logic [INPUT_BITS-1:0] RESET_CFG_SCANS [9] = '{
        16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
        16'h8000, 16'h8000, 16'h8000, 16'h0000
    };
    localparam logic [INPUT_BITS-1:0] FAST_CFG_SCANS [10] = '{
        16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFE, 16'h0000,
        16'h0003, 16'h0002, 16'h0002, 16'h0006, 16'h0000
    };

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: key 15 confirmed after four timer steps, then released
        foreach (RESET_CFG_SCANS[i])
            send_scan(RESET_CFG_SCANS[i]);

        // zero limit, step 1000 with junk in the upper data bits
        reconfigure(16'd0, 16'hFFE8);
        foreach (FAST_CFG_SCANS[i])
            send_scan(FAST_CFG_SCANS[i]);
        random_phase(120);

        reconfigure(LIMIT_RESET, STEP_RESET);
        random_phase(150);
        reconfigure(16'hFFFF, 16'd1000);
        random_phase(220);
        reconfigure(16'hFFFF, 16'd1);
        random_phase(40);
        reconfigure(16'd1, 16'd1);
        random_phase(120);
        // timer frozen: with a zero limit keys still confirm
        reconfigure(16'd0, 16'd0);
        random_phase(60);
        // timer frozen with a nonzero limit: a press never leaves debounce
        reconfigure(16'd5, 16'd0);
        random_phase(30);
        reconfigure(16'd100, 16'h03FF);
        random_phase(100);
        repeat (3)
        begin
            reconfigure(CFG_W'($urandom_range(0, 300)), CFG_W'($urandom_range(1, 1000)));
            random_phase(100);
        end

        drain();
        repeat (8) @(posedge clk);
        $display("Sent %0d scan beats across %0d register settings; %0d results checked,",
                 scans_sent, settings_run, tracker.checked);
        $display("%0d key releases reported, %0d mismatches.", tracker.releases,
                 tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Timed out with %0d results outstanding.", tracker.expected_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
rtl/mkds_pkg.sv
rtl/mkds_front.sv
rtl/mkds_queue.sv
rtl/mkds_back.sv
rtl/matrix_keypad_debounced_scanner.sv
tb/sv/tb_matrix_keypad_debounced_scanner.sv
